/* design/tlce_pkg.sv */
// tlce_pkg: constants and key codes for the two-line text cursor editor
// no dependencies; used by the interfaces and the top level

package tlce_pkg;

   localparam int COLUMNS      = 16;
   localparam int ROWS         = 2;
   localparam int COL_W        = $clog2(COLUMNS);
   localparam int KEY_W        = 8;
   localparam int GLYPH_W      = 8;
   localparam int FRAME_COL_W  = 4;

   localparam logic [KEY_W-1:0]   KEY_UP        = 8'd128;
   localparam logic [KEY_W-1:0]   KEY_DOWN      = 8'd129;
   localparam logic [KEY_W-1:0]   KEY_LEFT      = 8'd130;
   localparam logic [KEY_W-1:0]   KEY_RIGHT     = 8'd131;
   localparam logic [KEY_W-1:0]   KEY_BACKSPACE = 8'd8;
   localparam logic [KEY_W-1:0]   CHAR_SPACE    = 8'd32;
   localparam logic [KEY_W-1:0]   CHAR_LAST     = 8'd126;
   localparam logic [GLYPH_W-1:0] CURSOR_GLYPH  = 8'd255;

   localparam logic [COL_W-1:0]   LAST_COL      = COL_W'(COLUMNS - 1);

endpackage

/* design/tlce_req_if.sv */
// tlce_req_if: key request channel, valid/ready with the key byte
// depends on tlce_pkg

interface tlce_req_if import tlce_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

/* design/tlce_rsp_if.sv */
// tlce_rsp_if: frame character channel, valid/ready with row, column, glyph, last
// depends on tlce_pkg

interface tlce_rsp_if import tlce_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   frame_row;
   logic [FRAME_COL_W-1:0] frame_column;
   logic [GLYPH_W-1:0]     glyph;
   logic                   frame_last;

   modport source (output valid, output frame_row, output frame_column,
                   output glyph, output frame_last, input ready);
   modport sink   (input valid, input frame_row, input frame_column,
                   input glyph, input frame_last, output ready);
endinterface

/* design/two_line_text_cursor_editor.sv */
// two_line_text_cursor_editor: two-row text store with a block cursor
// depends on tlce_pkg, tlce_req_if, tlce_rsp_if

// When a key request is taken, the edit is written to the text memory and
// the cursor is updated in that same cycle; then the whole frame, row 0
// then row 1, column 0 upward, is read out of the memory one cell per
// cycle while the frame channel does not stall, and delivered with the
// cursor cell shown as 255, the last cell flagged. The frame scan walks
// through the single read port of the text memory; the next key is taken
// as soon as the scan has issued its last read, while the tail of the frame
// still drains. Back-pressure on the frame channel stalls the scan. The
// memory needs no clearing pass: per-cell valid bits, cleared by reset, make
// unwritten cells read as spaces.

module two_line_text_cursor_editor import tlce_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tlce_req_if.sink     req_chan,
   tlce_rsp_if.source   rsp_chan
);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type          state_ff, state_in;
   logic               cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic               scan_row_ff, scan_row_in;
   logic [COL_W-1:0]   scan_col_ff, scan_col_in;

   logic [GLYPH_W-1:0] text_mem [ROWS][COLUMNS];
   logic               cell_vld_ff [ROWS][COLUMNS];

   logic               wr_en;
   logic               wr_row;
   logic [COL_W-1:0]   wr_col;
   logic [GLYPH_W-1:0] wr_data;

   // read stage: data registered by the memory, tags alongside
   logic               pend_valid_ff;
   logic [GLYPH_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               pend_row_ff;
   logic [COL_W-1:0]   pend_col_ff;
   logic               pend_hit_ff;
   logic               pend_last_ff;

   logic                   out_valid_ff;
   logic                   out_row_ff;
   logic [FRAME_COL_W-1:0] out_col_ff;
   logic [GLYPH_W-1:0]     out_glyph_ff;
   logic                   out_last_ff;

   logic                   req_take;
   logic                   pend_move;
   logic                   rd_issue;
   logic [GLYPH_W-1:0]     pend_glyph;
   logic [COL_W+FRAME_COL_W-1:0] pend_col_ext;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign pend_move      = pend_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign rd_issue       = (state_ff == ST_SCAN) && (!pend_valid_ff || pend_move);

   // key decode: cursor update and the one cell write it may cause
   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      wr_en      = 1'b0;
      wr_row     = cur_row_ff;
      wr_col     = cur_col_ff;
      wr_data    = req_chan.key_code;
      if (req_take) begin
         case (req_chan.key_code) inside
            KEY_UP:    cur_row_in = 1'b0;
            KEY_DOWN:  cur_row_in = 1'b1;
            KEY_LEFT: begin
               if (cur_col_ff != '0) cur_col_in = cur_col_ff - 1'b1;
            end
            KEY_RIGHT: begin
               if (cur_col_ff != LAST_COL) cur_col_in = cur_col_ff + 1'b1;
            end
            KEY_BACKSPACE: begin
               if (cur_col_ff != '0) begin
                  cur_col_in = cur_col_ff - 1'b1;
                  wr_en      = 1'b1;
                  wr_col     = cur_col_ff - 1'b1;
                  wr_data    = CHAR_SPACE;
               end
            end
            [CHAR_SPACE:CHAR_LAST]: begin
               wr_en = 1'b1;
               if (cur_col_ff != LAST_COL) cur_col_in = cur_col_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // frame scan sequencer
   always_comb begin
      state_in    = state_ff;
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      if (req_take) begin
         state_in = ST_SCAN;
      end else if (rd_issue) begin
         if (scan_col_ff == LAST_COL) begin
            scan_col_in = '0;
            scan_row_in = !scan_row_ff;
            if (scan_row_ff) state_in = ST_IDLE;
         end else begin
            scan_col_in = scan_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cur_row_ff  <= 1'b0;
         cur_col_ff  <= '0;
         scan_row_ff <= 1'b0;
         scan_col_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         scan_row_ff <= scan_row_in;
         scan_col_ff <= scan_col_in;
      end
   end

   // text memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) text_mem[wr_row][wr_col] <= wr_data;
      if (rd_issue) begin
         rd_data_ff <= text_mem[scan_row_ff][scan_col_ff];
         rd_vld_ff  <= cell_vld_ff[scan_row_ff][scan_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
               cell_vld_ff[r][c] <= 1'b0;
            end
         end
      end else if (wr_en) begin
         cell_vld_ff[wr_row][wr_col] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (rd_issue) begin
         pend_valid_ff <= 1'b1;
      end else if (pend_move) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         pend_row_ff  <= scan_row_ff;
         pend_col_ff  <= scan_col_ff;
         pend_hit_ff  <= (scan_row_ff == cur_row_ff) && (scan_col_ff == cur_col_ff);
         pend_last_ff <= scan_row_ff && (scan_col_ff == LAST_COL);
      end
   end

   assign pend_glyph   = pend_hit_ff ? CURSOR_GLYPH : (rd_vld_ff ? rd_data_ff : CHAR_SPACE);
   assign pend_col_ext = {{FRAME_COL_W{1'b0}}, pend_col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pend_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         out_row_ff   <= pend_row_ff;
         out_col_ff   <= pend_col_ext[FRAME_COL_W-1:0];
         out_glyph_ff <= pend_glyph;
         out_last_ff  <= pend_last_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.frame_row    = out_row_ff;
   assign rsp_chan.frame_column = out_col_ff;
   assign rsp_chan.glyph        = out_glyph_ff;
   assign rsp_chan.frame_last   = out_last_ff;

   // scan counters sit at the first cell whenever a key can be taken
   a_idle_scan_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!scan_row_ff && scan_col_ff == '0))
      else $error("scan counters not at home while idle");

   // a taken key always starts a frame scan
   a_key_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SCAN))
      else $error("key request did not start a frame scan");

   // a read result never waits behind an empty output register
   a_pend_drains: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("read stage stuck with output register free");

   // no memory write while a scan is in progress
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !wr_en)
      else $error("text memory written during a frame scan");

endmodule
